FILE: src/kmks_pkg.sv
package kmks_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = FRAC_BITS;
    localparam int FLOOR_W    = FRAC_BITS - 1;
    localparam int SCAT_W     = FRAC_BITS + 1;
    localparam int ABS_W      = FRAC_BITS + 5;
    localparam int NUM_W      = 2 * FRAC_BITS;
    localparam int DEN_W      = FRAC_BITS + 1;
    localparam int PROD_W     = SCAT_W + NUM_W;
    localparam int PIPE_DEPTH = NUM_W + 5;
    localparam int CFG_W      = SCAT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 3 * IN_W;
    localparam int OUT_DATA_W = 3 * ABS_W + SCAT_W;

    localparam logic [IN_W:0]        ONE        = (IN_W + 1)'(1) << FRAC_BITS;
    localparam logic [IN_W-1:0]      DARK_LIMIT = IN_W'((1 << FRAC_BITS) / 10000);
    localparam logic [FRAC_BITS-1:0] HALF       = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [ABS_W-1:0]     ABS_MAX    = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPAQUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAIN  = 2'd2;

    localparam logic [FLOOR_W-1:0] FLOOR_RST  = FLOOR_W'(1966);
    localparam logic [SCAT_W-1:0]  OPAQUE_RST = SCAT_W'(104858);
    localparam logic [SCAT_W-1:0]  STAIN_RST  = SCAT_W'(22938);

    typedef struct packed {
        logic [FLOOR_W-1:0] refl_floor;
        logic [SCAT_W-1:0]  opaque;
        logic [SCAT_W-1:0]  stain;
    } cfg_t;

endpackage

FILE: src/kmks_div.sv
module kmks_div
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [kmks_pkg::NUM_W-1:0] num,
    input  logic [kmks_pkg::DEN_W-1:0] den,
    output logic [kmks_pkg::NUM_W-1:0] quo
);
    import kmks_pkg::*;

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [DEN_W-1:0] rem_next [NUM_W];
    logic [NUM_W-1:0] num_next [NUM_W];
    logic [NUM_W-1:0] quo_next [NUM_W];
    logic [DEN_W-1:0] den_next [NUM_W];

    // one quotient bit per stage, restoring
    always_comb
    begin
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   shifted;
        logic [DEN_W:0]   trial;
        for (int s = 0; s < NUM_W; s++)
        begin
            if (s == 0)
            begin
                rem_in = '0;
                num_in = num;
                quo_in = '0;
                den_in = den;
            end
            else
            begin
                rem_in = rem_reg[s-1];
                num_in = num_reg[s-1];
                quo_in = quo_reg[s-1];
                den_in = den_reg[s-1];
            end
            shifted = {rem_in, num_in[NUM_W-1]};
            trial   = shifted - {1'b0, den_in};
            if (!trial[DEN_W])
            begin
                rem_next[s] = trial[DEN_W-1:0];
                quo_next[s] = {quo_in[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = shifted[DEN_W-1:0];
                quo_next[s] = {quo_in[NUM_W-2:0], 1'b0};
            end
            num_next[s] = {num_in[NUM_W-2:0], 1'b0};
            den_next[s] = den_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NUM_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                num_reg[s] <= num_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_next[s];
            end
        end
    end

    assign quo = quo_reg[NUM_W-1];

endmodule

FILE: src/kmks_lane.sv
module kmks_lane
(
    input  logic                        clk,
    input  logic                        en,
    input  kmks_pkg::cfg_t              cfg,
    input  logic [kmks_pkg::IN_W-1:0]   refl,
    input  logic [kmks_pkg::SCAT_W-1:0] scat,
    output logic [kmks_pkg::ABS_W-1:0]  absorb
);
    import kmks_pkg::*;

    logic [IN_W-1:0]    fl;
    logic [IN_W-1:0]    hi;
    logic [IN_W-1:0]    r_clamp;
    logic [IN_W-1:0]    r_reg;
    logic [IN_W-1:0]    d_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [NUM_W-1:0]   ks;
    logic [NUM_W-1:0]   ks_d1_reg;
    logic [NUM_W-1:0]   ks_d2_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W:0]    rounded;
    logic [PROD_W-FRAC_BITS:0] k_full;

    // a zero floor acts as one so R never reaches zero
    always_comb
    begin
        fl = (cfg.refl_floor == '0) ? IN_W'(1) : IN_W'(cfg.refl_floor);
        hi = IN_W'(ONE - (IN_W + 1)'(fl));
        r_clamp = refl;
        if (r_clamp < fl)
            r_clamp = fl;
        if (r_clamp > hi)
            r_clamp = hi;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_clamp;
            d_reg     <= IN_W'(ONE - (IN_W + 1)'(r_clamp));
            num_reg   <= NUM_W'(d_reg * d_reg) + NUM_W'(r_reg);
            den_reg   <= {r_reg, 1'b0};
            ks_d1_reg <= ks;
            ks_d2_reg <= ks_d1_reg;
            prod_reg  <= PROD_W'(scat) * PROD_W'(ks_d2_reg);
        end
    end

    kmks_div u_div
    (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den_reg),
        .quo (ks)
    );

    always_comb
    begin
        rounded = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(HALF);
        k_full  = rounded[PROD_W:FRAC_BITS];
        if (k_full > (PROD_W - FRAC_BITS + 1)'(ABS_MAX))
            absorb = ABS_MAX;
        else
            absorb = k_full[ABS_W-1:0];
    end

endmodule

FILE: src/kmks_scatter.sv
module kmks_scatter
(
    input  logic                        clk,
    input  logic                        en,
    input  kmks_pkg::cfg_t              cfg,
    input  logic [kmks_pkg::IN_W-1:0]   red,
    input  logic [kmks_pkg::IN_W-1:0]   green,
    input  logic [kmks_pkg::IN_W-1:0]   blue,
    output logic [kmks_pkg::SCAT_W-1:0] scat_now,
    output logic [kmks_pkg::SCAT_W-1:0] scat_late
);
    import kmks_pkg::*;

    logic [IN_W-1:0]        mx;
    logic [IN_W-1:0]        mn;
    logic [IN_W-1:0]        mx_reg;
    logic [IN_W-1:0]        mn_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [NUM_W-1:0]       quo;
    logic                   up;
    logic [SCAT_W-1:0]      delta;
    logic                   up_reg;
    logic [SCAT_W+IN_W-1:0] prod_reg;
    logic [SCAT_W+IN_W:0]   rounded;
    logic [SCAT_W-1:0]      step;
    logic [SCAT_W-1:0]      scat_reg;
    logic [SCAT_W-1:0]      scat_late_reg;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx)
            mx = green;
        if (blue > mx)
            mx = blue;
        if (green < mn)
            mn = green;
        if (blue < mn)
            mn = blue;
        up    = (cfg.stain >= cfg.opaque);
        delta = up ? (cfg.stain - cfg.opaque) : (cfg.opaque - cfg.stain);
        rounded = (SCAT_W + IN_W + 1)'(prod_reg) + (SCAT_W + IN_W + 1)'(HALF);
        step    = rounded[FRAC_BITS+SCAT_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= mx;
            mn_reg <= mn;
            // dark pixel: divide zero by one so saturation comes out zero
            if (mx_reg <= DARK_LIMIT)
            begin
                num_reg <= '0;
                den_reg <= DEN_W'(1);
            end
            else
            begin
                num_reg <= {mx_reg - mn_reg, FRAC_BITS'(0)};
                den_reg <= {1'b0, mx_reg};
            end
            up_reg        <= up;
            // saturation reaches exactly one when the darkest channel is zero
            prod_reg      <= (SCAT_W + IN_W)'(delta) * (SCAT_W + IN_W)'(quo[IN_W:0]);
            scat_reg      <= up_reg ? (cfg.opaque + step) : (cfg.opaque - step);
            scat_late_reg <= scat_reg;
        end
    end

    kmks_div u_div
    (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    assign scat_now  = scat_reg;
    assign scat_late = scat_late_reg;

endmodule

FILE: src/kubelka_munk_ks_estimator_top.sv
// Kubelka-Munk absorption estimator: takes one RGB reflectance pixel per clock while the
// output is not stalled and returns K for each channel plus the shared scatter S. The
// 32-stage pipelined dividers (one quotient bit per stage) used for saturation and for
// (1-R)^2/(2R) let a new pixel enter before earlier ones finish; a stall on the output
// freezes the whole pipeline. Configuration registers are read live and must be
// written only while no pixel is in flight.
module kubelka_munk_ks_estimator_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [kmks_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [kmks_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // red_in[15:0], green_in[31:16], blue_in[47:32]
    input  logic [kmks_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // absorb_red[20:0], absorb_green[41:21], absorb_blue[62:42], scatter_out[79:63]
    output logic [kmks_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import kmks_pkg::*;

    cfg_t              cfg_reg;
    logic              adv;
    logic [PIPE_DEPTH-1:0] v_reg;
    logic              out_valid_reg;
    logic [SCAT_W-1:0] scat_now;
    logic [SCAT_W-1:0] scat_late;
    logic [ABS_W-1:0]  k_red;
    logic [ABS_W-1:0]  k_green;
    logic [ABS_W-1:0]  k_blue;
    logic [ABS_W-1:0]  out_red_reg;
    logic [ABS_W-1:0]  out_green_reg;
    logic [ABS_W-1:0]  out_blue_reg;
    logic [SCAT_W-1:0] out_scat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.refl_floor <= FLOOR_RST;
            cfg_reg.opaque     <= OPAQUE_RST;
            cfg_reg.stain      <= STAIN_RST;
        end
        else if (cfg_we)
        begin
            // drop writes beyond the last register
            unique case (cfg_addr)
                CFG_FLOOR:  cfg_reg.refl_floor <= cfg_wdata[FLOOR_W-1:0];
                CFG_OPAQUE: cfg_reg.opaque     <= cfg_wdata[SCAT_W-1:0];
                CFG_STAIN:  cfg_reg.stain      <= cfg_wdata[SCAT_W-1:0];
                default:    ;
            endcase
        end
    end

    // advance everything whenever the output register can move
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
            out_valid_reg <= v_reg[PIPE_DEPTH-1];
        end
    end

    kmks_scatter u_scatter
    (
        .clk       (clk),
        .en        (adv),
        .cfg       (cfg_reg),
        .red       (s_axis_tdata[IN_W-1:0]),
        .green     (s_axis_tdata[2*IN_W-1:IN_W]),
        .blue      (s_axis_tdata[3*IN_W-1:2*IN_W]),
        .scat_now  (scat_now),
        .scat_late (scat_late)
    );

    kmks_lane u_lane_red
    (
        .clk    (clk),
        .en     (adv),
        .cfg    (cfg_reg),
        .refl   (s_axis_tdata[IN_W-1:0]),
        .scat   (scat_now),
        .absorb (k_red)
    );

    kmks_lane u_lane_green
    (
        .clk    (clk),
        .en     (adv),
        .cfg    (cfg_reg),
        .refl   (s_axis_tdata[2*IN_W-1:IN_W]),
        .scat   (scat_now),
        .absorb (k_green)
    );

    kmks_lane u_lane_blue
    (
        .clk    (clk),
        .en     (adv),
        .cfg    (cfg_reg),
        .refl   (s_axis_tdata[3*IN_W-1:2*IN_W]),
        .scat   (scat_now),
        .absorb (k_blue)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_red_reg   <= k_red;
            out_green_reg <= k_green;
            out_blue_reg  <= k_blue;
            out_scat_reg  <= scat_late;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_scat_reg, out_blue_reg, out_green_reg, out_red_reg};

`ifndef NO_ASSERTIONS
    a_scat_between: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_scat_reg >= cfg_reg.opaque && out_scat_reg <= cfg_reg.stain) ||
             (out_scat_reg <= cfg_reg.opaque && out_scat_reg >= cfg_reg.stain)))
        else $error("scatter outside register range");

    a_zero_scat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_scat_reg == '0) |->
            (out_red_reg == '0 && out_green_reg == '0 && out_blue_reg == '0))
        else $error("nonzero absorption with zero scatter");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
